@@ rtl/hnm_pkg.sv @@
// Shared constants, types and the output encoder for the height-to-normal block.
package hnm_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;
	localparam logic [1:0] REG_SPHERE = 2'd3;

	localparam logic [47:0] Z_SQ     = 48'd4261478400;  // (255*256)^2
	localparam logic [23:0] Z_Q88    = 24'd65280;
	localparam logic [32:0] ONE_Q28  = 33'h010000000;

	typedef struct packed {
		logic        start;
		logic [47:0] radicand;
	} hnm_root_req_t;

	// 128 + 127*n in Q2.14, truncated and clamped to a byte
	function automatic logic [7:0] hnm_encode(input logic signed [15:0] n);
		logic signed [24:0] v;
		logic [7:0] r;
		v = 25'sd2097152 + 25'(n) * 25'sd127;
		if (v < 0) begin
			r = 8'd0;
		end else if (v[22:14] > 9'd255) begin
			r = 8'd255;
		end else begin
			r = v[21:14];
		end
		return r;
	endfunction

endpackage

@@ rtl/hnm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module hnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/hnm_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module hnm_isqrt
	import hnm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  hnm_root_req_t req,
	output logic          done,
	output logic [23:0]   root
);
	logic [47:0] v_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [47:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.radicand;
			r_q   <= 48'd0;
			bit_q <= 48'd1 << 46;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[23:0];
endmodule

@@ rtl/height_to_normal_map_top.sv @@
// Top level: height frame store and normal-map compute sequencer.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+------------------------------------
//  s_axis  | tvalid tready tdata[31:0] tuser[0:0] | store write or compute request
//  m_axis  | tvalid tready tdata[31:0]            | encoded normal and alpha
//  cfg     | valid ready index[1:0] data[15:0]    | register write, always ready
//
//  A compute request runs the 24-step square root and then the divider; sphere
//  mode adds a bias step and, when nx^2 + ny^2 is below one, a second root.
//  Five store reads go through the single read port of the frame RAM.
//  The output register lets a new request in while a result waits; a finished
//  compute holds until the output register frees up.
//  Reset restores control and configuration defaults; the frame store is not cleared.
module height_to_normal_map_top
	import hnm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // pixel_x, pixel_y, height_value, alpha_value
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // normal_x, normal_y, normal_z, alpha_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_SQR   = 4'd3;
	localparam logic [3:0] ST_SUMS  = 4'd4;
	localparam logic [3:0] ST_ROOT  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_BIAS  = 4'd7;
	localparam logic [3:0] ST_TSQ   = 4'd8;
	localparam logic [3:0] ST_TCHK  = 4'd9;
	localparam logic [3:0] ST_ROOT2 = 4'd10;
	localparam logic [3:0] ST_ENC   = 4'd11;

	// configuration
	logic [8:0]         width_q, height_q;
	logic signed [15:0] scale_q;
	logic               sphere_q;
	logic [8:0]         w_use, h_use;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'(MAX_WIDTH);
			height_q <= 9'(MAX_HEIGHT);
			scale_q  <= 16'sd256;
			sphere_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data[8:0];
				REG_SCALE:  scale_q  <= cfg_data;
				REG_SPHERE: sphere_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame size clamped to 1..max
	assign w_use = (width_q == 9'd0) ? 9'd1 :
		(width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_q;
	assign h_use = (height_q == 9'd0) ? 9'd1 :
		(height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_q;

	// request decode
	logic [7:0] in_x, in_y;
	logic       in_fire, in_inside;
	logic [3:0] state_q;
	logic [4:0] cnt_q;

	assign in_x      = s_axis_tdata[7:0];
	assign in_y      = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign in_inside = ({1'b0, in_x} < w_use) && ({1'b0, in_y} < h_use);

	// frame store: [7:0] height, [15:8] alpha, addressed {y, x}
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;
	logic [7:0]        x_q, y_q, x_lf, x_rt, y_dn, y_up;

	assign ram_we = in_fire && !s_axis_tuser && in_inside;
	assign ram_re = (state_q == ST_READ) && (cnt_q < 5'd5);

	assign x_lf = (x_q == 8'd0) ? 8'(w_use - 9'd1) : x_q - 8'd1;
	assign x_rt = (({1'b0, x_q} + 9'd1) == w_use) ? 8'd0 : x_q + 8'd1;
	assign y_dn = (({1'b0, y_q} + 9'd1) == h_use) ? 8'd0 : y_q + 8'd1;
	assign y_up = (y_q == 8'd0) ? 8'(h_use - 9'd1) : y_q - 8'd1;

	always_comb begin
		unique case (cnt_q[2:0])
			3'd0:    ram_raddr = {y_q, x_lf};
			3'd1:    ram_raddr = {y_q, x_rt};
			3'd2:    ram_raddr = {y_dn, x_q};
			3'd3:    ram_raddr = {y_up, x_q};
			default: ram_raddr = {y_q, x_q};
		endcase
	end

	hnm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({in_y, in_x}),
		.wdata ({s_axis_tdata[31:24], s_axis_tdata[23:16]}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// gradient datapath
	logic [7:0]         h_lf_q, h_rt_q, h_dn_q, h_up_q, alpha_q;
	logic signed [9:0]  diff_x, diff_y;
	logic signed [15:0] scale_eff;
	logic signed [25:0] ddx_q, ddy_q;
	logic [23:0]        mag_x, mag_y, mx_q, my_q;
	logic               negx_q, negy_q;
	logic [47:0]        sqx_q, sqy_q;

	assign diff_x    = $signed({2'b0, h_lf_q}) - $signed({2'b0, h_rt_q});
	assign diff_y    = $signed({2'b0, h_dn_q}) - $signed({2'b0, h_up_q});
	assign scale_eff = (scale_q == 16'sd0) ? 16'sd256 : scale_q;
	assign mag_x     = ddx_q[25] ? 24'(-ddx_q) : ddx_q[23:0];
	assign mag_y     = ddy_q[25] ? 24'(-ddy_q) : ddy_q[23:0];

	// square root, shared by the norm and the sphere z
	hnm_root_req_t root_req;
	logic          root_done;
	logic [23:0]   root;
	logic [32:0]   t_sum;
	logic [31:0]   tx_q, ty_q;

	assign t_sum = {1'b0, tx_q} + {1'b0, ty_q};

	always_comb begin
		root_req.start    = (state_q == ST_SUMS) ||
			((state_q == ST_TCHK) && (t_sum < ONE_Q28));
		root_req.radicand = (state_q == ST_SUMS) ? (sqx_q + sqy_q + Z_SQ) :
			{19'd0, 29'(ONE_Q28) - {1'b0, t_sum[27:0]}};
	end

	hnm_isqrt u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.done   (root_done),
		.root   (root)
	);

	// five divider lanes: nx, ny, nz, x bias, y bias
	logic [24:0] rem_q [5];
	logic [15:0] num_q [5];
	logic [15:0] quo_q [5];
	logic [23:0] dvs_q [5];
	logic        neg_q [5];
	logic [24:0] rem_sh [5];
	logic        rem_ge [5];
	logic [15:0] q_sgn [5];

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			rem_sh[i] = {rem_q[i][23:0], num_q[i][15]};
			rem_ge[i] = rem_sh[i] >= {1'b0, dvs_q[i]};
			q_sgn[i]  = neg_q[i] ? 16'(-quo_q[i]) : quo_q[i];
		end
	end

	logic signed [9:0]  bxs, bys;
	logic [23:0]        mag_bx, mag_by;
	logic [23:0]        ld_mag [5];

	assign bxs    = $signed({1'b0, x_q, 1'b0}) - $signed({1'b0, w_use});
	assign bys    = $signed({1'b0, h_use}) - $signed({1'b0, y_q, 1'b0});
	assign mag_bx = 24'(bxs[9] ? -bxs : bxs);
	assign mag_by = 24'(bys[9] ? -bys : bys);
	assign ld_mag[0] = mx_q;
	assign ld_mag[1] = my_q;
	assign ld_mag[2] = Z_Q88;
	assign ld_mag[3] = mag_bx;
	assign ld_mag[4] = mag_by;

	// normal components, Q2.14
	logic signed [15:0] nx_q, ny_q, nz_q, bx_q, by_q;
	logic signed [16:0] sum_x, sum_y;
	logic signed [31:0] sq_nx, sq_ny;

	assign sum_x = 17'(nx_q) + 17'(bx_q);
	assign sum_y = 17'(ny_q) + 17'(by_q);
	assign sq_nx = nx_q * nx_q;
	assign sq_ny = ny_q * ny_q;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// output register
	logic        out_valid_q, out_load;
	logic [31:0] out_data_q;

	assign out_load      = (state_q == ST_ENC) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {alpha_q, hnm_encode(nz_q), hnm_encode(ny_q), hnm_encode(nx_q)};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= 5'd0;
					if (in_fire && s_axis_tuser && in_inside) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_SUMS;
				ST_SUMS: state_q <= ST_ROOT;
				ST_ROOT: begin
					cnt_q <= 5'd0;
					if (root_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= sphere_q ? ST_BIAS : ST_ENC;
					end
				end
				ST_BIAS: state_q <= ST_TSQ;
				ST_TSQ:  state_q <= ST_TCHK;
				ST_TCHK: state_q <= (t_sum < ONE_Q28) ? ST_ROOT2 : ST_ENC;
				ST_ROOT2: begin
					if (root_done) begin
						state_q <= ST_ENC;
					end
				end
				ST_ENC: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= in_x;
			y_q <= in_y;
		end
		if (state_q == ST_READ) begin
			unique case (cnt_q)
				5'd1:    h_lf_q  <= ram_rdata[7:0];
				5'd2:    h_rt_q  <= ram_rdata[7:0];
				5'd3:    h_dn_q  <= ram_rdata[7:0];
				5'd4:    h_up_q  <= ram_rdata[7:0];
				5'd5:    alpha_q <= ram_rdata[15:8];
				default: ;
			endcase
		end
		if (state_q == ST_MUL) begin
			ddx_q <= 26'(diff_x) * 26'(scale_eff);
			ddy_q <= 26'(diff_y) * 26'(scale_eff);
		end
		if (state_q == ST_SQR) begin
			sqx_q  <= {24'd0, mag_x} * {24'd0, mag_x};
			sqy_q  <= {24'd0, mag_y} * {24'd0, mag_y};
			mx_q   <= mag_x;
			my_q   <= mag_y;
			negx_q <= ddx_q[25];
			negy_q <= ddy_q[25];
		end
		if ((state_q == ST_ROOT) && root_done) begin
			for (int i = 0; i < 5; i++) begin
				rem_q[i] <= {3'd0, ld_mag[i][23:2]};
				num_q[i] <= {ld_mag[i][1:0], 14'd0};
				quo_q[i] <= 16'd0;
			end
			dvs_q[0] <= root;
			dvs_q[1] <= root;
			dvs_q[2] <= root;
			dvs_q[3] <= {15'd0, w_use};
			dvs_q[4] <= {15'd0, h_use};
			neg_q[0] <= negx_q;
			neg_q[1] <= negy_q;
			neg_q[2] <= 1'b0;
			neg_q[3] <= bxs[9];
			neg_q[4] <= bys[9];
		end
		if (state_q == ST_DIV) begin
			if (cnt_q < 5'd16) begin
				for (int i = 0; i < 5; i++) begin
					rem_q[i] <= rem_ge[i] ? rem_sh[i] - {1'b0, dvs_q[i]} : rem_sh[i];
					num_q[i] <= {num_q[i][14:0], 1'b0};
					quo_q[i] <= {quo_q[i][14:0], rem_ge[i]};
				end
			end else begin
				nx_q <= q_sgn[0];
				ny_q <= q_sgn[1];
				nz_q <= q_sgn[2];
				bx_q <= q_sgn[3];
				by_q <= q_sgn[4];
			end
		end
		if (state_q == ST_BIAS) begin
			nx_q <= sat16(sum_x);
			ny_q <= sat16(sum_y);
		end
		if (state_q == ST_TSQ) begin
			tx_q <= unsigned'(sq_nx);
			ty_q <= unsigned'(sq_ny);
		end
		if ((state_q == ST_ROOT2) && root_done) begin
			nz_q <= signed'(root[15:0]);
		end
	end

`ifndef NO_ASSERTIONS
	a_root_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == ST_ROOT) || (state_q == ST_ROOT2))
		else $error("root result arrived outside a root wait state");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= 5'd16))
		else $error("divider ran past its last step");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
		else $error("pending result overwritten");
	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (state_q == ST_IDLE))
		else $error("store write started a compute");
`endif
endmodule
